// ===== design/zff_pkg.sv =====
// ----------------------------------------------------------------------------
// zff_pkg
// Shared constants, types and the square-root step of the z-expansion
// form factor evaluator.
// ----------------------------------------------------------------------------
package zff_pkg;

  localparam int FRAC       = 24;
  localparam int NUM_COEF   = 4;
  localparam int RAD_W      = 66;
  localparam int ROOT_W     = 32;
  localparam int A_W        = 28;
  localparam int Z_W        = 26;
  localparam int ROOT_STEPS = 28;
  localparam int DIV_STEPS  = 25;
  localparam int OFF_STEPS  = 32;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_NEG = 2'd1;
  localparam logic [1:0] ST_SAT = 2'd2;

  localparam logic [2:0] REG_THRESH = 3'd0;
  localparam logic [2:0] REG_QMAX   = 3'd1;
  localparam logic [2:0] REG_OPT    = 3'd2;
  localparam logic [2:0] REG_COUNT  = 3'd3;
  localparam logic [2:0] REG_COEF0  = 3'd4;
  localparam logic [2:0] REG_COEF1  = 3'd5;
  localparam logic [2:0] REG_COEF2  = 3'd6;
  localparam logic [2:0] REG_COEF3  = 3'd7;

  localparam logic [30:0] THRESH_RESET = 31'h0100_0000;
  // sqrt(2^24 * 2^24) = 2^24, i.e. 1.0 in Q8.24: offset root for the reset threshold
  localparam logic [A_W-1:0] B_RESET   = 28'h100_0000;
  localparam logic [23:0]    FRAC_MASK = 24'hFF_FFFF;

  typedef struct packed {
    logic valid;
    logic neg;
  } pipe_ctl_t;

  typedef struct packed {
    logic [RAD_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sq_step_t;

  // One restoring digit of the integer square root at bit k.
  function automatic sq_step_t sq_step(input sq_step_t cur, input logic [4:0] k);
    logic [RAD_W-1:0] trial;
    sq_step_t         nxt;
    trial = ({{(RAD_W-ROOT_W){1'b0}}, cur.root} << ({1'b0, k} + 6'd1))
          | ({{(RAD_W-1){1'b0}}, 1'b1} << {k, 1'b0});
    nxt = cur;
    if (cur.rem >= trial) begin
      nxt.rem  = cur.rem - trial;
      nxt.root = cur.root | ({{(ROOT_W-1){1'b0}}, 1'b1} << k);
    end
    return nxt;
  endfunction

endpackage

// ===== design/zff_offset.sv =====
// ----------------------------------------------------------------------------
// zff_offset
// Sequential unit that derives the offset root sqrt(tcut - t0) from the
// configuration, one root bit per cycle.
// ----------------------------------------------------------------------------
module zff_offset (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     kick,
  input  logic [30:0]              thresh,
  input  logic [30:0]              qmax,
  input  logic                     opt_on,
  output logic                     busy,
  output logic [zff_pkg::A_W-1:0]  b_root
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_MUL    = 2'd1;
  localparam logic [1:0] S_ROOT_D = 2'd2;
  localparam logic [1:0] S_ROOT_B = 2'd3;
  localparam logic [4:0] K_TOP    = 5'(zff_pkg::OFF_STEPS - 1);

  logic [1:0]               state_r;
  logic                     kick_r;
  logic [4:0]               k_r;
  zff_pkg::sq_step_t        sq_r;
  zff_pkg::sq_step_t        step_nxt;
  logic [zff_pkg::A_W-1:0]  b_r;
  logic [63:0]              prod;

  assign step_nxt = zff_pkg::sq_step(sq_r, k_r);
  assign prod     = {33'd0, thresh} * ({1'b0, thresh} + {1'b0, qmax});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      kick_r  <= 1'b0;
      k_r     <= '0;
      b_r     <= zff_pkg::B_RESET;
    end else begin
      kick_r <= kick;
      if (kick_r) begin
        // restart from the freshly written registers
        k_r <= K_TOP;
        if (opt_on) begin
          state_r <= S_MUL;
        end else begin
          sq_r    <= '{rem: {11'd0, thresh, 24'd0}, root: '0};
          state_r <= S_ROOT_B;
        end
      end else begin
        unique case (state_r)
          S_IDLE: begin
          end
          S_MUL: begin
            sq_r    <= '{rem: {2'd0, prod}, root: '0};
            k_r     <= K_TOP;
            state_r <= S_ROOT_D;
          end
          S_ROOT_D: begin
            if (k_r == '0) begin
              sq_r    <= '{rem: {10'd0, step_nxt.root, 24'd0}, root: '0};
              k_r     <= K_TOP;
              state_r <= S_ROOT_B;
            end else begin
              sq_r <= step_nxt;
              k_r  <= k_r - 5'd1;
            end
          end
          S_ROOT_B: begin
            if (k_r == '0) begin
              b_r     <= step_nxt.root[zff_pkg::A_W-1:0];
              state_r <= S_IDLE;
            end else begin
              sq_r <= step_nxt;
              k_r  <= k_r - 5'd1;
            end
          end
          default: state_r <= S_IDLE;
        endcase
      end
    end
  end

  assign busy   = kick_r || (state_r != S_IDLE);
  assign b_root = b_r;

endmodule

// ===== design/zff_root_pipe.sv =====
// ----------------------------------------------------------------------------
// zff_root_pipe
// Pipelined integer square root of (tcut + qsq) * 2^24, one root bit per stage.
// ----------------------------------------------------------------------------
module zff_root_pipe (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv,
  input  zff_pkg::pipe_ctl_t       in_ctl,
  input  logic [55:0]              in_rad,
  output zff_pkg::pipe_ctl_t       out_ctl,
  output logic [zff_pkg::A_W-1:0]  out_root
);

  localparam int N = zff_pkg::ROOT_STEPS;

  zff_pkg::pipe_ctl_t ctl_r [N];
  zff_pkg::sq_step_t  st_r  [N];

  for (genvar g = 0; g < N; g++) begin : g_stage
    zff_pkg::sq_step_t  cur;
    zff_pkg::pipe_ctl_t ctl_in;

    if (g == 0) begin : g_first
      assign cur    = '{rem: {10'd0, in_rad}, root: '0};
      assign ctl_in = in_ctl;
    end else begin : g_next
      assign cur    = st_r[g-1];
      assign ctl_in = ctl_r[g-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[g] <= '0;
      end else if (adv) begin
        ctl_r[g] <= ctl_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st_r[g] <= zff_pkg::sq_step(cur, 5'(N - 1 - g));
      end
    end
  end

  assign out_ctl  = ctl_r[N-1];
  assign out_root = st_r[N-1].root[zff_pkg::A_W-1:0];

endmodule

// ===== design/zff_div_pipe.sv =====
// ----------------------------------------------------------------------------
// zff_div_pipe
// Pipelined restoring divider forming z = (a - b) * 2^24 / (a + b),
// one quotient bit per stage, truncated toward zero.
// ----------------------------------------------------------------------------
module zff_div_pipe (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            adv,
  input  zff_pkg::pipe_ctl_t              in_ctl,
  input  logic [zff_pkg::A_W-1:0]         in_a,
  input  logic [zff_pkg::A_W-1:0]         in_b,
  output zff_pkg::pipe_ctl_t              out_ctl,
  output logic signed [zff_pkg::Z_W-1:0]  out_z
);

  localparam int N = zff_pkg::DIV_STEPS;

  typedef struct packed {
    logic [52:0] rem;
    logic [28:0] den;
    logic [24:0] quo;
    logic        sgn;
  } div_st_t;

  zff_pkg::pipe_ctl_t ctl_r [N];
  div_st_t            st_r  [N];
  div_st_t            head;
  logic [27:0]        mag;

  assign mag  = (in_a >= in_b) ? (in_a - in_b) : (in_b - in_a);
  assign head = '{rem: {1'b0, mag, 24'd0},
                  den: {1'b0, in_a} + {1'b0, in_b},
                  quo: '0,
                  sgn: (in_a < in_b)};

  for (genvar g = 0; g < N; g++) begin : g_stage
    div_st_t            cur;
    div_st_t            nxt;
    zff_pkg::pipe_ctl_t ctl_in;
    logic [52:0]        trial;

    if (g == 0) begin : g_first
      assign cur    = head;
      assign ctl_in = in_ctl;
    end else begin : g_next
      assign cur    = st_r[g-1];
      assign ctl_in = ctl_r[g-1];
    end

    assign trial = {24'd0, cur.den} << (N - 1 - g);

    always_comb begin
      nxt = cur;
      if (cur.rem >= trial) begin
        nxt.rem          = cur.rem - trial;
        nxt.quo[N-1-g]   = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[g] <= '0;
      end else if (adv) begin
        ctl_r[g] <= ctl_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st_r[g] <= nxt;
      end
    end
  end

  // both roots zero: take z as zero
  always_comb begin
    if (st_r[N-1].den == '0) begin
      out_z = '0;
    end else if (st_r[N-1].sgn) begin
      out_z = -$signed({1'b0, st_r[N-1].quo});
    end else begin
      out_z = $signed({1'b0, st_r[N-1].quo});
    end
  end

  assign out_ctl = ctl_r[N-1];

endmodule

// ===== design/zff_series.sv =====
// ----------------------------------------------------------------------------
// zff_series
// Powers of z, coefficient products, exact sum and saturation, ending in the
// output register.
// ----------------------------------------------------------------------------
module zff_series #(
  parameter int MAX_TERMS = zff_pkg::NUM_COEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            adv,
  input  zff_pkg::pipe_ctl_t              in_ctl,
  input  logic signed [zff_pkg::Z_W-1:0]  in_z,
  input  logic signed [31:0]              coef [zff_pkg::NUM_COEF],
  input  logic [2:0]                      term_count,
  output logic                            out_valid,
  output logic signed [31:0]              out_form_factor,
  output logic [1:0]                      out_status
);

  localparam int NC = 7;

  zff_pkg::pipe_ctl_t      ctl_r [NC];
  logic signed [25:0]      z1_r, z2_r, z3_r, z4_r, z5_r;
  logic signed [51:0]      sq_r, cu_r;
  logic signed [25:0]      zz3_r, zz4_r, zz5_r, zzz5_r;
  logic signed [57:0]      term_r [zff_pkg::NUM_COEF];
  logic signed [59:0]      acc_r;
  logic                    out_valid_r;
  logic signed [31:0]      out_ff_r;
  logic [1:0]              out_st_r;

  logic [2:0]              n_eff;
  logic signed [51:0]      sq_adj, cu_adj;
  logic signed [59:0]      acc_adj, acc_sum;
  logic signed [35:0]      quo;
  logic signed [25:0]      zp [zff_pkg::NUM_COEF];

  always_comb begin
    priority if (term_count == '0) begin
      n_eff = 3'd1;
    end else if (term_count > 3'(MAX_TERMS)) begin
      n_eff = 3'(MAX_TERMS);
    end else begin
      n_eff = term_count;
    end
  end

  // truncate toward zero: bias negatives before the arithmetic shift
  assign sq_adj = sq_r + $signed({28'd0, sq_r[51] ? zff_pkg::FRAC_MASK : 24'd0});
  assign cu_adj = cu_r + $signed({28'd0, cu_r[51] ? zff_pkg::FRAC_MASK : 24'd0});

  assign zp[0] = 26'sd0;
  assign zp[1] = z5_r;
  assign zp[2] = zz5_r;
  assign zp[3] = zzz5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < NC; j++) begin
        ctl_r[j] <= '0;
      end
      out_valid_r <= 1'b0;
    end else if (adv) begin
      ctl_r[0] <= in_ctl;
      for (int j = 1; j < NC; j++) begin
        ctl_r[j] <= ctl_r[j-1];
      end
      out_valid_r <= ctl_r[NC-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      z1_r   <= in_z;
      z2_r   <= z1_r;
      sq_r   <= z1_r * z1_r;
      z3_r   <= z2_r;
      zz3_r  <= sq_adj[49:24];
      z4_r   <= z3_r;
      zz4_r  <= zz3_r;
      cu_r   <= zz3_r * z3_r;
      z5_r   <= z4_r;
      zz5_r  <= zz4_r;
      zzz5_r <= cu_adj[49:24];
    end
  end

  for (genvar i = 0; i < zff_pkg::NUM_COEF; i++) begin : g_term
    always_ff @(posedge clk) begin
      if (adv) begin
        if (3'(i) >= n_eff) begin
          term_r[i] <= '0;
        end else if (i == 0) begin
          term_r[i] <= $signed({{2{coef[i][31]}}, coef[i], 24'd0});
        end else begin
          term_r[i] <= coef[i] * zp[i];
        end
      end
    end
  end

  always_comb begin
    acc_sum = '0;
    for (int i = 0; i < zff_pkg::NUM_COEF; i++) begin
      acc_sum = acc_sum + 60'(term_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      acc_r <= acc_sum;
    end
  end

  assign acc_adj = acc_r + $signed({36'd0, acc_r[59] ? zff_pkg::FRAC_MASK : 24'd0});
  assign quo     = acc_adj[59:24];

  always_ff @(posedge clk) begin
    if (adv) begin
      priority if (ctl_r[NC-1].neg) begin
        out_ff_r <= '0;
        out_st_r <= zff_pkg::ST_NEG;
      end else if (quo > 36'sd2147483647) begin
        out_ff_r <= 32'sh7FFF_FFFF;
        out_st_r <= zff_pkg::ST_SAT;
      end else if (quo < -36'sd2147483648) begin
        out_ff_r <= 32'sh8000_0000;
        out_st_r <= zff_pkg::ST_SAT;
      end else begin
        out_ff_r <= quo[31:0];
        out_st_r <= zff_pkg::ST_OK;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_form_factor = out_ff_r;
  assign out_status      = out_st_r;

endmodule

// ===== design/z_expansion_form_factor_eval_top.sv =====
// ----------------------------------------------------------------------------
// z_expansion_form_factor_eval_top
// Evaluates F(qsq) = sum coef_i * z^i with z from the conformal map, Q8.24.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_ready carry one momentum transfer qsq per
// transfer. Result channel: out_valid/out_ready carry the form factor and a
// status code (ok, negative radicand, saturated) per transfer.
// Registers sit on an APB-style port at byte addresses 4*i; pready is tied
// high and reads return the stored values.
// Throughput is one item per cycle unless out_ready holds the pipeline or the
// offset root unit is busy. Each result passes 28 square-root stages, 25 divider
// stages and 8 series stages (powers, products, sum, saturation, output register).
// A write to the threshold, max or optimal-t0 register starts the offset
// root unit; in_ready stays low while it runs.
// Reset restores the register defaults and empties the pipeline; the offset
// root of the default threshold is loaded directly, so no pass follows reset.
// When out_ready is low with a result waiting, the whole pipeline holds and
// in_ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module z_expansion_form_factor_eval_top #(
  parameter int MAX_TERMS = zff_pkg::NUM_COEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_momentum_sq,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_form_factor,
  output logic [1:0]         out_status,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [30:0]         thresh_r;
  logic [30:0]         qmax_r;
  logic                opt_r;
  logic [2:0]          count_r;
  logic signed [31:0]  coef_r [zff_pkg::NUM_COEF];

  logic                wr_en;
  logic [2:0]          wr_idx;
  logic                kick;
  logic                busy;
  logic [zff_pkg::A_W-1:0] b_root;

  logic                adv;
  logic signed [33:0]  sum_s;
  logic [55:0]         rad;
  zff_pkg::pipe_ctl_t  in_ctl;
  zff_pkg::pipe_ctl_t  root_ctl;
  zff_pkg::pipe_ctl_t  div_ctl;
  logic [zff_pkg::A_W-1:0]         a_root;
  logic signed [zff_pkg::Z_W-1:0]  z_val;

  // configuration port
  assign pready = 1'b1;
  assign wr_idx = paddr[4:2];
  assign wr_en  = psel && penable && pwrite && pready;
  assign kick   = wr_en && ((wr_idx == zff_pkg::REG_THRESH) ||
                            (wr_idx == zff_pkg::REG_QMAX) ||
                            (wr_idx == zff_pkg::REG_OPT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= zff_pkg::THRESH_RESET;
      qmax_r   <= '0;
      opt_r    <= 1'b0;
      count_r  <= 3'd1;
      for (int i = 0; i < zff_pkg::NUM_COEF; i++) begin
        coef_r[i] <= '0;
      end
    end else if (wr_en) begin
      unique case (wr_idx)
        zff_pkg::REG_THRESH: thresh_r  <= pwdata[30:0];
        zff_pkg::REG_QMAX:   qmax_r    <= pwdata[30:0];
        zff_pkg::REG_OPT:    opt_r     <= pwdata[0];
        zff_pkg::REG_COUNT:  count_r   <= pwdata[2:0];
        zff_pkg::REG_COEF0:  coef_r[0] <= pwdata;
        zff_pkg::REG_COEF1:  coef_r[1] <= pwdata;
        zff_pkg::REG_COEF2:  coef_r[2] <= pwdata;
        zff_pkg::REG_COEF3:  coef_r[3] <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (wr_idx)
      zff_pkg::REG_THRESH: prdata = {1'b0, thresh_r};
      zff_pkg::REG_QMAX:   prdata = {1'b0, qmax_r};
      zff_pkg::REG_OPT:    prdata = {31'd0, opt_r};
      zff_pkg::REG_COUNT:  prdata = {29'd0, count_r};
      zff_pkg::REG_COEF0:  prdata = coef_r[0];
      zff_pkg::REG_COEF1:  prdata = coef_r[1];
      zff_pkg::REG_COEF2:  prdata = coef_r[2];
      zff_pkg::REG_COEF3:  prdata = coef_r[3];
      default:             prdata = '0;
    endcase
  end

  zff_offset u_offset (
    .clk    (clk),
    .rst_n  (rst_n),
    .kick   (kick),
    .thresh (thresh_r),
    .qmax   (qmax_r),
    .opt_on (opt_r),
    .busy   (busy),
    .b_root (b_root)
  );

  // whole pipeline advances when the output register is free or drained
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv && !busy;

  assign sum_s = $signed({3'd0, thresh_r}) + $signed({{2{in_momentum_sq[31]}}, in_momentum_sq});
  assign rad   = sum_s[33] ? '0 : {sum_s[31:0], 24'd0};

  assign in_ctl = '{valid: in_valid && !busy, neg: sum_s[33]};

  zff_root_pipe u_root (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_ctl   (in_ctl),
    .in_rad   (rad),
    .out_ctl  (root_ctl),
    .out_root (a_root)
  );

  zff_div_pipe u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_ctl  (root_ctl),
    .in_a    (a_root),
    .in_b    (b_root),
    .out_ctl (div_ctl),
    .out_z   (z_val)
  );

  zff_series #(
    .MAX_TERMS (MAX_TERMS)
  ) u_series (
    .clk             (clk),
    .rst_n           (rst_n),
    .adv             (adv),
    .in_ctl          (div_ctl),
    .in_z            (z_val),
    .coef            (coef_r),
    .term_count      (count_r),
    .out_valid       (out_valid),
    .out_form_factor (out_form_factor),
    .out_status      (out_status)
  );

  a_neg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == zff_pkg::ST_NEG) |-> (out_form_factor == 32'sd0))
    else $error("negative radicand result is not zero");

  a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == zff_pkg::ST_SAT) |->
      ((out_form_factor == 32'sh7FFF_FFFF) || (out_form_factor == 32'sh8000_0000)))
    else $error("saturated result is off the rails");

  a_busy_block: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_ready)
    else $error("input taken while offset root is recomputed");

endmodule
